### rtl/core/msc_pkg.sv
// Shared types, constants and CRC-16/MODBUS helpers for the speed command framer.
// No dependencies; msc_crc and the top level refer to this package by scoped name.
package msc_pkg;

    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned CRC_DATA_W = 40;   // unit address, register address, value

    localparam logic [PADDR_W-1:0] ADDR_DRIVE_LIMIT = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_TARGET_REG  = 3'd4;

    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [14:0] LIMIT_RESET       = 15'd1000;
    localparam logic [15:0] TARGET_REG_RESET  = 16'h0040;

    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] function_byte;
        logic [7:0] register_high;
        logic [7:0] register_low;
        logic [7:0] value_high;
        logic [7:0] value_low;
        logic [7:0] crc_low;
        logic [7:0] crc_high;
        logic       was_clipped;
    } t_frame;

    // One byte through the reflected CRC, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Full six-byte frame CRC; data packs {unit, register[15:0], value[15:0]}.
    function automatic logic [15:0] crc_frame(input logic [CRC_DATA_W-1:0] data);
        logic [15:0] c;
        c = crc_byte(CRC_INIT, data[39:32]);
        c = crc_byte(c, FUNC_WRITE_SINGLE);
        c = crc_byte(c, data[31:24]);
        c = crc_byte(c, data[23:16]);
        c = crc_byte(c, data[15:8]);
        c = crc_byte(c, data[7:0]);
        return c;
    endfunction

    // Contribution of one data bit; the CRC is affine in the data bits.
    function automatic logic [15:0] crc_column(input int unsigned k);
        logic [CRC_DATA_W-1:0] v;
        v = {{(CRC_DATA_W-1){1'b0}}, 1'b1} << k;
        return crc_frame(v) ^ crc_frame('0);
    endfunction

endpackage

### rtl/core/msc_cmd_if.sv
// Request channel of the framer: unit address and raw signed speed command.
// No dependencies.
interface msc_cmd_if;
    logic               valid;
    logic               ready;
    logic [7:0]         unit_address;
    logic signed [31:0] drive_value;

    modport source (output valid, output unit_address, output drive_value, input ready);
    modport sink   (input valid, input unit_address, input drive_value, output ready);
endinterface

### rtl/core/msc_frame_if.sv
// Result channel of the framer: the eight frame bytes and the clip flag.
// No dependencies.
interface msc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_address_byte;
    logic [7:0] frame_function_byte;
    logic [7:0] frame_register_high;
    logic [7:0] frame_register_low;
    logic [7:0] frame_value_high;
    logic [7:0] frame_value_low;
    logic [7:0] frame_crc_low;
    logic [7:0] frame_crc_high;
    logic       was_clipped;

    modport source (
        output valid, input ready,
        output frame_address_byte, output frame_function_byte,
        output frame_register_high, output frame_register_low,
        output frame_value_high, output frame_value_low,
        output frame_crc_low, output frame_crc_high, output was_clipped
    );
    modport sink (
        input valid, output ready,
        input frame_address_byte, input frame_function_byte,
        input frame_register_high, input frame_register_low,
        input frame_value_high, input frame_value_low,
        input frame_crc_low, input frame_crc_high, input was_clipped
    );
endinterface

### rtl/core/msc_crc.sv
// CRC-16/MODBUS of the six-byte write-single-register header as one XOR tree.
// Depends on msc_pkg for the per-bit columns and the constant offset.
module msc_crc (
    input  logic [msc_pkg::CRC_DATA_W-1:0] i_data,
    output logic [15:0]                    o_crc
);

    localparam logic [15:0] CRC_BASE = msc_pkg::crc_frame('0);

    logic [15:0] w_term [msc_pkg::CRC_DATA_W];

    for (genvar k = 0; k < msc_pkg::CRC_DATA_W; k++) begin : g_col
        localparam logic [15:0] COL = msc_pkg::crc_column(k);
        assign w_term[k] = COL & {16{i_data[k]}};
    end

    always_comb begin
        o_crc = CRC_BASE;
        for (int k = 0; k < msc_pkg::CRC_DATA_W; k++) begin
            o_crc = o_crc ^ w_term[k];
        end
    end

endmodule

### rtl/core/modbus_speed_command_framer.sv
// Top level of the Modbus RTU speed command framer.
// Depends on msc_pkg, msc_cmd_if, msc_frame_if and msc_crc.
//
// Usage:
//   i_cmd carries one request: a slave unit address and a signed 32-bit speed
//   command. o_frame returns one result per request: the complete 8-byte
//   write-single-register frame (address, 0x06, register high/low, value
//   high/low, CRC low/high) plus a flag set when the command was saturated.
//   The APB port writes drive_limit at 0x0 and target_register_address at
//   0x4; reads return the current values. Write it only while idle.
//
// Pipeline and throughput:
//   A request taken on i_cmd goes into the input register; the saturation
//   and the CRC tree fill the result register from it when that is free, and
//   the result register drives o_frame. One request per cycle is sustained
//   while the receiver does not stall; the limit is the single pass of
//   compare, clip and a 40-input XOR tree per CRC bit.
//
// Reset and stall:
//   Reset drops both pipeline valids and restores drive_limit to 1000 and
//   the target register to 0x0040. While the receiver stalls the result
//   register holds; the input register still takes one more request, then
//   i_cmd.ready falls until the result is taken.
module modbus_speed_command_framer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    msc_cmd_if.sink                      i_cmd,
    msc_frame_if.source                  o_frame,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // Configuration registers
    logic [14:0] r_drive_limit;
    logic [15:0] r_target_reg;

    // Input stage
    logic               r_in_valid;
    logic [7:0]         r_unit;
    logic signed [31:0] r_value;

    // Result stage
    logic               r_out_valid;
    msc_pkg::t_frame    r_frame;
    msc_pkg::t_frame    n_frame;

    logic               w_out_load_ok;
    logic               w_in_advance;
    logic               w_accept;
    logic signed [31:0] w_lim_pos;
    logic signed [31:0] w_lim_neg;
    logic [15:0]        w_sat;
    logic               w_clip;
    logic [15:0]        w_crc;

    assign pready = 1'b1;

    // Register write at the APB access phase; unknown addresses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_limit <= msc_pkg::LIMIT_RESET;
            r_target_reg  <= msc_pkg::TARGET_REG_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr)
                msc_pkg::ADDR_DRIVE_LIMIT: r_drive_limit <= pwdata[14:0];
                msc_pkg::ADDR_TARGET_REG:  r_target_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            msc_pkg::ADDR_DRIVE_LIMIT: prdata = {17'd0, r_drive_limit};
            msc_pkg::ADDR_TARGET_REG:  prdata = {16'd0, r_target_reg};
            default:                   prdata = '0;
        endcase
    end

    // Handshake: the result register frees when empty or taken; the input
    // register frees when empty or moving into the result register.
    assign w_out_load_ok = !r_out_valid || o_frame.ready;
    assign w_in_advance  = r_in_valid && w_out_load_ok;
    assign i_cmd.ready   = !r_in_valid || w_out_load_ok;
    assign w_accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_unit  <= i_cmd.unit_address;
            r_value <= i_cmd.drive_value;
        end
    end

    // Saturate to +-limit; a command exactly at the limit passes unflagged.
    assign w_lim_pos = signed'({17'd0, r_drive_limit});
    assign w_lim_neg = -w_lim_pos;

    always_comb begin
        if (r_value > w_lim_pos) begin
            w_sat  = w_lim_pos[15:0];
            w_clip = 1'b1;
        end else if (r_value < w_lim_neg) begin
            w_sat  = w_lim_neg[15:0];
            w_clip = 1'b1;
        end else begin
            w_sat  = r_value[15:0];
            w_clip = 1'b0;
        end
    end

    msc_crc u_crc (
        .i_data ({r_unit, r_target_reg, w_sat}),
        .o_crc  (w_crc)
    );

    always_comb begin
        n_frame.address_byte  = r_unit;
        n_frame.function_byte = msc_pkg::FUNC_WRITE_SINGLE;
        n_frame.register_high = r_target_reg[15:8];
        n_frame.register_low  = r_target_reg[7:0];
        n_frame.value_high    = w_sat[15:8];
        n_frame.value_low     = w_sat[7:0];
        n_frame.crc_low       = w_crc[7:0];
        n_frame.crc_high      = w_crc[15:8];
        n_frame.was_clipped   = w_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load_ok) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Hold the frame while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (w_in_advance) begin
            r_frame <= n_frame;
        end
    end

    assign o_frame.valid               = r_out_valid;
    assign o_frame.frame_address_byte  = r_frame.address_byte;
    assign o_frame.frame_function_byte = r_frame.function_byte;
    assign o_frame.frame_register_high = r_frame.register_high;
    assign o_frame.frame_register_low  = r_frame.register_low;
    assign o_frame.frame_value_high    = r_frame.value_high;
    assign o_frame.frame_value_low     = r_frame.value_low;
    assign o_frame.frame_crc_low       = r_frame.crc_low;
    assign o_frame.frame_crc_high      = r_frame.crc_high;
    assign o_frame.was_clipped         = r_frame.was_clipped;

endmodule
